// File: rtl/svtt_pkg.sv
// Shared constants and lookup functions for the sensor voltage linearizer.
// Holds the descending voltage table, the temperature points and the span reciprocals.
// No dependencies.
package svtt_pkg;

    // Number of points stored in the calibration table.
    localparam int STORED_POINTS = 33;
    // Width of a point index into the stored table.
    localparam int PT_IDX_W = 6;
    // Width of the cell code and of the temperature output.
    localparam int CODE_W = 16;
    localparam int TEMP_W = 12;
    // Width of a stored temperature point in whole degrees.
    localparam int DEG_W = 8;
    // Largest voltage span of one segment, and its width.
    localparam int MAX_SPAN = 700;
    localparam int SPAN_W = 10;
    // Temperature step between adjacent points, in whole degrees.
    localparam int DEG_STEP = 5;
    // Out-of-range marker in whole degrees.
    localparam int MARKER_DEG = -100;
    // Reciprocals are ceil(2^RECIP_SHIFT / span), exact for numerator * span < 2^RECIP_SHIFT.
    localparam int RECIP_SHIFT = 32;
    localparam int RECIP_W = 26;

    // Sensor voltage at each table point, in 100 uV code units (descending).
    function automatic logic [CODE_W-1:0] volt_pt(input logic [PT_IDX_W-1:0] idx);
        logic [CODE_W-1:0] v;
        unique case (idx)
            6'd0:    v = 16'd24400;
            6'd1:    v = 16'd24200;
            6'd2:    v = 16'd24000;
            6'd3:    v = 16'd23800;
            6'd4:    v = 16'd23500;
            6'd5:    v = 16'd23200;
            6'd6:    v = 16'd22700;
            6'd7:    v = 16'd22300;
            6'd8:    v = 16'd21700;
            6'd9:    v = 16'd21100;
            6'd10:   v = 16'd20500;
            6'd11:   v = 16'd19900;
            6'd12:   v = 16'd19200;
            6'd13:   v = 16'd18600;
            6'd14:   v = 16'd18000;
            6'd15:   v = 16'd17400;
            6'd16:   v = 16'd16800;
            6'd17:   v = 16'd16300;
            6'd18:   v = 16'd15900;
            6'd19:   v = 16'd15500;
            6'd20:   v = 16'd15100;
            6'd21:   v = 16'd14800;
            6'd22:   v = 16'd14500;
            6'd23:   v = 16'd14300;
            6'd24:   v = 16'd14000;
            6'd25:   v = 16'd13800;
            6'd26:   v = 16'd13700;
            6'd27:   v = 16'd13500;
            6'd28:   v = 16'd13400;
            6'd29:   v = 16'd13300;
            6'd30:   v = 16'd13200;
            6'd31:   v = 16'd13100;
            6'd32:   v = 16'd13000;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

    // Temperature at each table point, in whole degrees C.
    function automatic logic signed [DEG_W-1:0] deg_pt(input logic [PT_IDX_W-1:0] idx);
        logic signed [DEG_W-1:0] t;
        unique case (idx)
            6'd0:    t = -8'sd40;
            6'd1:    t = -8'sd35;
            6'd2:    t = -8'sd30;
            6'd3:    t = -8'sd25;
            6'd4:    t = -8'sd20;
            6'd5:    t = -8'sd15;
            6'd6:    t = -8'sd10;
            6'd7:    t = -8'sd5;
            6'd8:    t = 8'sd0;
            6'd9:    t = 8'sd5;
            6'd10:   t = 8'sd10;
            6'd11:   t = 8'sd15;
            6'd12:   t = 8'sd20;
            6'd13:   t = 8'sd25;
            6'd14:   t = 8'sd30;
            6'd15:   t = 8'sd35;
            6'd16:   t = 8'sd40;
            6'd17:   t = 8'sd45;
            6'd18:   t = 8'sd50;
            6'd19:   t = 8'sd55;
            6'd20:   t = 8'sd60;
            6'd21:   t = 8'sd65;
            6'd22:   t = 8'sd70;
            6'd23:   t = 8'sd75;
            6'd24:   t = 8'sd80;
            6'd25:   t = 8'sd85;
            6'd26:   t = 8'sd90;
            6'd27:   t = 8'sd95;
            6'd28:   t = 8'sd100;
            6'd29:   t = 8'sd105;
            6'd30:   t = 8'sd110;
            6'd31:   t = 8'sd115;
            6'd32:   t = 8'sd120;
            default: t = 8'sd0;
        endcase
        return t;
    endfunction

    // Voltage span of the segment that starts at point idx.
    function automatic logic [SPAN_W-1:0] seg_span(input logic [PT_IDX_W-1:0] idx);
        logic [CODE_W-1:0] diff;
        diff = volt_pt(idx) - volt_pt(idx + 6'd1);
        return diff[SPAN_W-1:0];
    endfunction

    // Rounded-up reciprocal of each span that occurs in the table.
    function automatic logic [RECIP_W-1:0] span_recip(input logic [SPAN_W-1:0] span);
        logic [RECIP_W-1:0] r;
        unique case (span)
            10'd100: r = 26'd42949673;
            10'd200: r = 26'd21474837;
            10'd300: r = 26'd14316558;
            10'd400: r = 26'd10737419;
            10'd500: r = 26'd8589935;
            10'd600: r = 26'd7158279;
            10'd700: r = 26'd6135668;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/svtt_seg_find.sv
// Segment search for the voltage linearizer: compares the code against every segment
// in parallel and picks the first one that brackets it. Depends on svtt_pkg.
module svtt_seg_find
    import svtt_pkg::*;
#(
    parameter int NSEG  = 32,
    parameter int SEG_W = 5
)
(
    input  logic [CODE_W-1:0] code,
    output logic              hit,
    output logic [SEG_W-1:0]  seg_idx,
    output logic [SPAN_W-1:0] span_dist
);

    logic [NSEG-1:0]   in_seg;
    logic [CODE_W-1:0] hi_sel;
    logic [CODE_W-1:0] diff;

    // Each segment checks both of its end points, inclusive.
    always_comb
    begin
        for (int j = 0; j < NSEG; j++)
        begin
            in_seg[j] = (code <= volt_pt(PT_IDX_W'(j))) && (code >= volt_pt(PT_IDX_W'(j + 1)));
        end
    end

    // The lowest-numbered bracketing segment wins on a shared point.
    always_comb
    begin
        seg_idx = '0;
        for (int j = NSEG - 1; j >= 0; j--)
        begin
            if (in_seg[j])
            begin
                seg_idx = SEG_W'(j);
            end
        end
    end

    assign hit = |in_seg;

    // Distance below the upper point of the chosen segment; never above its span.
    assign hi_sel    = volt_pt(PT_IDX_W'(seg_idx));
    assign diff      = hi_sel - code;
    assign span_dist = diff[SPAN_W-1:0];

endmodule

// File: rtl/sensor_voltage_to_temperature_unit.sv
// Top level of the sensor voltage to temperature linearizer.
// Depends on svtt_pkg and svtt_seg_find.
//
// Converts a cell code in 100 uV units into a temperature in 1/2^FRAC_BITS degree C by
// linear interpolation over a fixed descending 33-point table (2.44 V at -40 C down to
// 1.30 V at 120 C). Codes outside the table span give the -100 C marker with
// out_of_range set. The block takes one transaction per clock while the output is not
// stalled and presents each result on out_valid after it passes through an input register,
// a segment-select stage that forms the rounding numerator, and an interpolation stage
// whose reciprocal multiply does the division by the segment span feeding the output
// register. All stages advance together whenever the output register is empty or
// being drained, so a stalled result holds the whole pipe.
module sensor_voltage_to_temperature_unit
    import svtt_pkg::*;
#(
    parameter int TABLE_POINTS = 33,
    parameter int FRAC_BITS    = 4
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [CODE_W-1:0]        cell_code,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [TEMP_W-1:0] temp_sixteenths,
    output logic                     out_of_range
);

    localparam int NPTS    = (TABLE_POINTS < STORED_POINTS) ? TABLE_POINTS : STORED_POINTS;
    localparam int NSEG    = NPTS - 1;
    localparam int SEG_W   = (NSEG > 1) ? $clog2(NSEG) : 1;
    localparam int NUM_W   = $clog2(MAX_SPAN * DEG_STEP * (2 ** FRAC_BITS) + MAX_SPAN);
    localparam int PROD_W  = NUM_W + RECIP_W;
    localparam int QW      = FRAC_BITS + 3;
    localparam int Q_MAX   = DEG_STEP * (2 ** FRAC_BITS);
    localparam int SUM_RAW = DEG_W + FRAC_BITS + 2;
    localparam int SUM_W   = (SUM_RAW > TEMP_W) ? SUM_RAW : TEMP_W;
    localparam int MARKER_FULL = MARKER_DEG * (2 ** FRAC_BITS);
    localparam logic [TEMP_W-1:0] MARKER = TEMP_W'(MARKER_FULL);

    logic advance;

    // Input stage registers.
    logic              s1_vld_reg;
    logic [CODE_W-1:0] code_reg;

    // Segment-select stage.
    logic              seg_hit;
    logic [SEG_W-1:0]  seg_idx;
    logic [SPAN_W-1:0] seg_dist;
    logic [SPAN_W-1:0] span_s1;
    logic [NUM_W-1:0]  numer_next;
    logic              s2_vld_reg;
    logic [SEG_W-1:0]  seg_reg;
    logic [NUM_W-1:0]  numer_reg;
    logic              oor_reg;

    // Interpolation stage.
    logic [RECIP_W-1:0] recip_s2;
    logic [PROD_W-1:0]  prod;
    logic [QW-1:0]      q_next;
    logic [SUM_W-1:0]   base;
    logic [SUM_W-1:0]   sum;
    logic [TEMP_W-1:0]  temp_next;
    logic               out_vld_reg;
    logic [TEMP_W-1:0]  temp_reg;
    logic               oor_out_reg;

    // The pipe moves whenever the output register can take a new result.
    assign advance  = !out_vld_reg || out_ready;
    assign in_ready = advance;

    // Valid flags of all stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_vld_reg  <= in_valid;
            s2_vld_reg  <= s1_vld_reg;
            out_vld_reg <= s2_vld_reg;
        end
    end

    // Input register capture.
    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            code_reg <= cell_code;
        end
    end

    svtt_seg_find #(
        .NSEG  (NSEG),
        .SEG_W (SEG_W)
    ) u_seg_find (
        .code      (code_reg),
        .hit       (seg_hit),
        .seg_idx   (seg_idx),
        .span_dist (seg_dist)
    );

    // Rounding numerator: dist * step * 2^FRAC_BITS plus half the span.
    assign span_s1    = seg_span(PT_IDX_W'(seg_idx));
    assign numer_next = ((NUM_W'(seg_dist) * NUM_W'(DEG_STEP)) << FRAC_BITS)
                        + NUM_W'(span_s1 >> 1);

    always_ff @(posedge clk)
    begin
        if (advance && s1_vld_reg)
        begin
            seg_reg   <= seg_idx;
            numer_reg <= numer_next;
            oor_reg   <= !seg_hit;
        end
    end

    // Division by the span through its reciprocal, then the segment base is added.
    assign recip_s2 = span_recip(seg_span(PT_IDX_W'(seg_reg)));
    assign prod     = PROD_W'(numer_reg) * PROD_W'(recip_s2);
    assign q_next   = prod[RECIP_SHIFT +: QW];
    assign base     = SUM_W'(deg_pt(PT_IDX_W'(seg_reg))) << FRAC_BITS;
    assign sum      = base + SUM_W'(q_next);

    always_comb
    begin
        if (oor_reg)
        begin
            temp_next = MARKER;
        end
        else
        begin
            temp_next = sum[TEMP_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s2_vld_reg)
        begin
            temp_reg    <= temp_next;
            oor_out_reg <= oor_reg;
        end
    end

    assign out_valid       = out_vld_reg;
    assign temp_sixteenths = temp_reg;
    assign out_of_range    = oor_out_reg;

    // The distance into a chosen segment never exceeds that segment's span.
    a_dist_in_span: assert property (@(posedge clk) disable iff (!rst_n)
        s1_vld_reg && seg_hit |-> seg_dist <= span_s1)
        else $error("segment distance exceeds segment span");

    // The interpolated fraction never exceeds one full temperature step.
    a_frac_bound: assert property (@(posedge clk) disable iff (!rst_n)
        s2_vld_reg && !oor_reg |-> q_next <= QW'(Q_MAX))
        else $error("interpolated fraction exceeds one segment step");

    // An out-of-range result always carries the marker value.
    a_marker: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && oor_out_reg |-> temp_reg == MARKER)
        else $error("out-of-range result without marker value");

    // A held result moves on only when the pipe advances.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && !out_ready |=> out_vld_reg && $stable(temp_reg) && $stable(oor_out_reg))
        else $error("stalled result changed");

endmodule

// File: dv/sensor_voltage_to_temperature_unit_checker.sv
// Checker for the sensor voltage to temperature linearizer.
// Predicts each temperature from the calibration table and compares it with the block output.
// Depends on svtt_pkg for the port widths and the table constants.
module sensor_voltage_to_temperature_unit_checker
    import svtt_pkg::*;
#(
    parameter int TABLE_POINTS = 33,
    parameter int FRAC_BITS    = 4
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic                     in_ready,
    input  logic [CODE_W-1:0]        cell_code,
    input  logic                     out_valid,
    input  logic                     out_ready,
    input  logic signed [TEMP_W-1:0] temp_sixteenths,
    input  logic                     out_of_range,
    output int                       fail_count,
    output int                       pending_results
);

    // One predicted conversion, kept with the code that caused it.
    typedef struct packed {
        logic [CODE_W-1:0]        code;
        logic signed [TEMP_W-1:0] temp;
        logic                     oor;
    } temp_expect_t;

    // Sensor voltage at each calibration point in 100 uV units, descending.
    // Point i sits at -40 + 5*i degrees C.
    int unsigned sensor_volts [0:32] = '{
        24400, 24200, 24000, 23800, 23500, 23200, 22700, 22300, 21700, 21100,
        20500, 19900, 19200, 18600, 18000, 17400, 16800, 16300, 15900, 15500,
        15100, 14800, 14500, 14300, 14000, 13800, 13700, 13500, 13400, 13300,
        13200, 13100, 13000
    };

    temp_expect_t expected_temps [$];

    // Linear interpolation over the first segment that brackets the code.
    function automatic temp_expect_t linearize_code(input logic [CODE_W-1:0] code);
        temp_expect_t res;
        int           used_points;
        int           scale;
        int           hi;
        int           lo;
        int           frac;
        int           deg_hi;
        int           temp_full;
        bit           found;
        used_points = (TABLE_POINTS < STORED_POINTS) ? TABLE_POINTS : STORED_POINTS;
        scale       = 1 << FRAC_BITS;
        found       = 1'b0;
        res.code    = code;
        res.oor     = 1'b1;
        temp_full   = MARKER_DEG * scale;
        for (int i = 0; i + 1 < used_points; i++)
        begin
            hi = sensor_volts[i];
            lo = sensor_volts[i + 1];
            if (!found && int'(code) <= hi && int'(code) >= lo)
            begin
                found     = 1'b1;
                deg_hi    = -40 + DEG_STEP * i;
                frac      = ((hi - int'(code)) * DEG_STEP * scale + (hi - lo) / 2) / (hi - lo);
                temp_full = deg_hi * scale + frac;
                res.oor   = 1'b0;
            end
        end
        res.temp = temp_full[TEMP_W-1:0];
        return res;
    endfunction

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        fail_count++;
    endtask

    // Retire results first, then record the prediction for a newly accepted code.
    always @(posedge clk)
    begin
        temp_expect_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_temps.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result temp=%0d oor=%0b",
                                              temp_sixteenths, out_of_range));
                end
                else
                begin
                    want = expected_temps.pop_front();
                    if (temp_sixteenths !== want.temp)
                        report_mismatch($sformatf("code %0d: temp_sixteenths %0d, expected %0d",
                                                  want.code, temp_sixteenths, want.temp));
                    if (out_of_range !== want.oor)
                        report_mismatch($sformatf("code %0d: out_of_range %0b, expected %0b",
                                                  want.code, out_of_range, want.oor));
                end
            end
            if (in_valid && in_ready)
                expected_temps.push_back(linearize_code(cell_code));
            pending_results <= expected_temps.size();
        end
    end

endmodule

// File: dv/sensor_voltage_to_temperature_unit_tb.sv
// Testbench top for the sensor voltage to temperature linearizer.
// Drives directed and random cell codes with bursty input and stalling output.
// Depends on svtt_pkg, the block and sensor_voltage_to_temperature_unit_checker.
module sensor_voltage_to_temperature_unit_tb;
    import svtt_pkg::*;

    localparam int TABLE_POINTS  = 33;
    localparam int FRAC_BITS     = 4;
    localparam int RANDOM_CODES  = 550;
    localparam int IDLE_LIMIT    = 1000;
    localparam int DRAIN_CYCLES  = 8;

    // Output stall patterns.
    typedef enum int {DRAIN_ALWAYS, DRAIN_COIN, DRAIN_SPARSE, DRAIN_PERIODIC} drain_mode_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic [CODE_W-1:0]        cell_code = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic signed [TEMP_W-1:0] temp_sixteenths;
    logic                     out_of_range;
    int                       fail_count;
    int                       pending_results;

    int                       burst_left = 0;
    int                       idle_cycles = 0;
    int                       drain_run = 0;
    int                       drain_phase = 0;
    drain_mode_t              drain_mode = DRAIN_ALWAYS;

    // Clock with a period of 20.
    always #10 clk = ~clk;

    sensor_voltage_to_temperature_unit #(
        .TABLE_POINTS (TABLE_POINTS),
        .FRAC_BITS    (FRAC_BITS)
    ) u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .cell_code       (cell_code),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .temp_sixteenths (temp_sixteenths),
        .out_of_range    (out_of_range)
    );

    sensor_voltage_to_temperature_unit_checker #(
        .TABLE_POINTS (TABLE_POINTS),
        .FRAC_BITS    (FRAC_BITS)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .cell_code       (cell_code),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .temp_sixteenths (temp_sixteenths),
        .out_of_range    (out_of_range),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    // Receiver: switch at random between stall patterns.
    always @(negedge clk)
    begin
        if (drain_run == 0)
        begin
            drain_mode <= drain_mode_t'($urandom_range(0, 3));
            drain_run  <= $urandom_range(20, 120);
        end
        else
        begin
            drain_run <= drain_run - 1;
        end
        drain_phase <= drain_phase + 1;
        case (drain_mode)
            DRAIN_ALWAYS:   out_ready <= 1'b1;
            DRAIN_COIN:     out_ready <= 1'($urandom_range(0, 1));
            DRAIN_SPARSE:   out_ready <= ($urandom_range(0, 3) == 0);
            DRAIN_PERIODIC: out_ready <= (drain_phase % 5 != 0);
            default:        out_ready <= 1'b1;
        endcase
    end

    // Watchdog: end the run when no transaction moves for too long.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Present one code until it is accepted, then close the burst with a gap if due.
    task automatic send_code(input logic [CODE_W-1:0] code);
        int gap;
        cell_code <= code;
        in_valid  <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            gap        = $urandom_range(1, 12);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(0, 8);
            in_valid  <= 1'b0;
            cell_code <= CODE_W'($urandom);
            repeat (gap) @(negedge clk);
        end
    endtask

    // Random code: mostly inside the table, some on or next to a multiple of 100, some anywhere.
    function automatic logic [CODE_W-1:0] pick_code();
        int pick;
        int code;
        pick = $urandom_range(0, 9);
        if (pick < 2)
            code = $urandom_range(0, 65535);
        else if (pick < 4)
            code = $urandom_range(130, 244) * 100 + $urandom_range(0, 2) - 1;
        else
            code = $urandom_range(13000, 24400);
        return code[CODE_W-1:0];
    endfunction

    initial
    begin
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: field extremes, table ends and their neighbors, shared points.
        send_code(16'd0);
        send_code(16'd65535);
        send_code(16'h5555);
        send_code(16'hAAAA);
        send_code(16'd24401);
        send_code(16'd24400);
        send_code(16'd24399);
        send_code(16'd24300);
        send_code(16'd24200);
        send_code(16'd22701);
        send_code(16'd21700);
        send_code(16'd19550);
        send_code(16'd17100);
        send_code(16'd14150);
        send_code(16'd13750);
        send_code(16'd13100);
        send_code(16'd13001);
        send_code(16'd13000);
        send_code(16'd12999);
        send_code(16'd32768);

        // Random codes.
        for (int n = 0; n < RANDOM_CODES; n++)
            send_code(pick_code());

        in_valid <= 1'b0;
        while (pending_results != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fail_count == 0 && pending_results == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: sim.f
rtl/svtt_pkg.sv
rtl/svtt_seg_find.sv
rtl/sensor_voltage_to_temperature_unit.sv
dv/sensor_voltage_to_temperature_unit_checker.sv
dv/sensor_voltage_to_temperature_unit_tb.sv
